// ===== rtl/core/swks_pkg.sv =====
// swks_pkg: sizes, codes and shared types of the sliding window k-smallest sum block
// used by swks_cell, swks_chain and sliding_window_k_smallest_sum; depends on nothing
package swks_pkg;

  localparam int WINDOW_MAX  = 256;
  localparam int SAMPLE_BITS = 32;
  localparam int SUM_BITS    = 40;
  localparam int CFG_BITS    = 9;
  localparam int IDX_BITS    = $clog2(WINDOW_MAX);
  localparam int FILL_BITS   = $clog2(WINDOW_MAX + 1);

  // cells are read out through a registered two-level select, sixteen cells a group
  localparam int GRP_BITS = 4;
  localparam int GRP_SIZE = 1 << GRP_BITS;
  localparam int NUM_GRP  = (WINDOW_MAX + GRP_SIZE - 1) / GRP_SIZE;

  // register index, taken from paddr[2]
  localparam logic REG_WINDOW_LENGTH = 1'b0;
  localparam logic REG_KEEP_COUNT    = 1'b1;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_DEL,
    OP_INS
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEL,
    ST_DEL,
    ST_INS
  } state_t;

  typedef struct packed {
    cell_op_t               op;
    logic [SAMPLE_BITS-1:0] sample;
    logic [IDX_BITS-1:0]    del_idx;
    logic [FILL_BITS-1:0]   fill;
    logic [IDX_BITS-1:0]    age_top;
  } cell_ctrl_t;

  typedef struct packed {
    logic                   del_any;
    logic [GRP_BITS-1:0]    del_loc;
    logic [SAMPLE_BITS-1:0] del_val;
    logic [SAMPLE_BITS-1:0] k_val;
    logic [SAMPLE_BITS-1:0] km1_val;
  } grp_sel_t;

endpackage

// ===== rtl/core/swks_cell.sv =====
// swks_cell: one cell of the sorted chain, holding a value and its age
// depends on swks_pkg; instantiated by swks_chain
module swks_cell (
  input  logic                             clk,
  input  logic [swks_pkg::IDX_BITS-1:0]    idx,
  input  swks_pkg::cell_ctrl_t             ctrl,
  input  logic                             prev_gt,
  input  logic [swks_pkg::SAMPLE_BITS-1:0] prev_value,
  input  logic [swks_pkg::IDX_BITS-1:0]    prev_age,
  input  logic [swks_pkg::SAMPLE_BITS-1:0] next_value,
  input  logic [swks_pkg::IDX_BITS-1:0]    next_age,
  output logic [swks_pkg::SAMPLE_BITS-1:0] value,
  output logic [swks_pkg::IDX_BITS-1:0]    age,
  output logic                             gt,
  output logic                             match
);
  import swks_pkg::*;

  logic [SAMPLE_BITS-1:0] value_r, value_nxt;
  logic [IDX_BITS-1:0]    age_r, age_nxt;
  logic                   valid;

  always_comb begin
    valid = FILL_BITS'(idx) < ctrl.fill;
    // invalid cells count as greater so the insert point stays at the fill edge
    gt    = !valid || (value_r > ctrl.sample);
    match = valid && (age_r == ctrl.age_top);

    value_nxt = value_r;
    age_nxt   = age_r;
    case (ctrl.op)
      OP_DEL: begin
        if (valid && (idx >= ctrl.del_idx)) begin
          value_nxt = next_value;
          age_nxt   = next_age;
        end
      end
      OP_INS: begin
        if (!gt) begin
          age_nxt = age_r + IDX_BITS'(1);
        end else if (!prev_gt) begin
          value_nxt = ctrl.sample;
          age_nxt   = '0;
        end else begin
          value_nxt = prev_value;
          age_nxt   = prev_age + IDX_BITS'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    age_r   <= age_nxt;
  end

  assign value = value_r;
  assign age   = age_r;

endmodule

// ===== rtl/core/swks_chain.sv =====
// swks_chain: row of swks_cell with neighbor links and the first, registered select level
// depends on swks_pkg and swks_cell
module swks_chain (
  input  logic                           clk,
  input  swks_pkg::cell_ctrl_t           ctrl,
  input  logic [swks_pkg::FILL_BITS-1:0] keep,
  input  logic                           grp_en,
  output swks_pkg::grp_sel_t             grp [swks_pkg::NUM_GRP]
);
  import swks_pkg::*;

  logic [SAMPLE_BITS-1:0] value_w [WINDOW_MAX];
  logic [IDX_BITS-1:0]    age_w   [WINDOW_MAX];
  logic                   gt_w    [WINDOW_MAX];
  logic                   match_w [WINDOW_MAX];

  grp_sel_t grp_r [NUM_GRP];
  grp_sel_t grp_nxt [NUM_GRP];

  for (genvar gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
    logic                   prev_gt;
    logic [SAMPLE_BITS-1:0] prev_value;
    logic [IDX_BITS-1:0]    prev_age;
    logic [SAMPLE_BITS-1:0] next_value;
    logic [IDX_BITS-1:0]    next_age;

    if (gi == 0) begin : g_first
      assign prev_gt    = 1'b0;
      assign prev_value = '0;
      assign prev_age   = '0;
    end else begin : g_mid
      assign prev_gt    = gt_w[gi-1];
      assign prev_value = value_w[gi-1];
      assign prev_age   = age_w[gi-1];
    end

    if (gi == WINDOW_MAX - 1) begin : g_last
      assign next_value = '0;
      assign next_age   = '0;
    end else begin : g_inner
      assign next_value = value_w[gi+1];
      assign next_age   = age_w[gi+1];
    end

    swks_cell u_cell (
      .clk        (clk),
      .idx        (IDX_BITS'(gi)),
      .ctrl       (ctrl),
      .prev_gt    (prev_gt),
      .prev_value (prev_value),
      .prev_age   (prev_age),
      .next_value (next_value),
      .next_age   (next_age),
      .value      (value_w[gi]),
      .age        (age_w[gi]),
      .gt         (gt_w[gi]),
      .match      (match_w[gi])
    );
  end

  // one-hot picks inside each group: the retiring cell, cell keep and cell keep-1
  always_comb begin
    int i;
    for (int g = 0; g < NUM_GRP; g++) begin
      grp_nxt[g] = '0;
      for (int j = 0; j < GRP_SIZE; j++) begin
        i = g * GRP_SIZE + j;
        if (i < WINDOW_MAX) begin
          if (match_w[i]) begin
            grp_nxt[g].del_any = 1'b1;
            grp_nxt[g].del_loc = grp_nxt[g].del_loc | GRP_BITS'(j);
            grp_nxt[g].del_val = grp_nxt[g].del_val | value_w[i];
          end
          if (FILL_BITS'(i) == keep) begin
            grp_nxt[g].k_val = grp_nxt[g].k_val | value_w[i];
          end
          if (FILL_BITS'(i + 1) == keep) begin
            grp_nxt[g].km1_val = grp_nxt[g].km1_val | value_w[i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (grp_en) begin
      grp_r <= grp_nxt;
    end
  end

  assign grp = grp_r;

endmodule

// ===== rtl/core/sliding_window_k_smallest_sum.sv =====
// sliding_window_k_smallest_sum: top level with control, running sum and register port
// depends on swks_pkg and swks_chain
//
// Samples arrive on in_valid/in_ready/in_sample and are kept in a chain of cells
// sorted by value, each cell also holding the age of its sample. Once window_length
// samples are held, every sample gives one result on out_valid/out_ready/
// out_smallest_sum: the sum of the keep_count smallest values in the window
// (keep_count clamped to the window length, zero gives a sum of zero).
// Each sample goes through a select cycle, which reads the retiring cell and the
// cells at the keep boundary through a two-level registered select, a delete cycle,
// which closes the gap of the oldest cell, and an insert cycle, which opens a gap at
// the sorted place. The next sample is taken in the insert cycle, so a new sample is
// accepted only once the select and delete cycles of the last one are through.
// A result is written to the output register in the insert cycle of its sample.
// If that register still holds an untaken result when the next one is due, the
// insert cycle waits and the chain holds until out_ready.
// Reset sets both registers to 1 and empties the window; no clearing pass is needed
// since only cells below the fill count are ever read. Writing either register over
// the APB port (0x0 window_length, 0x4 keep_count) empties the window as well.
module sliding_window_k_smallest_sum (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [swks_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [swks_pkg::SUM_BITS-1:0]    out_smallest_sum,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import swks_pkg::*;

  state_t                 state_r, state_nxt;
  logic [SAMPLE_BITS-1:0] sample_r, sample_nxt;
  logic [FILL_BITS-1:0]   fill_r, fill_nxt;
  logic [SUM_BITS-1:0]    sum_r, sum_nxt;
  logic [SAMPLE_BITS-1:0] vkm1_r, vkm1_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [SUM_BITS-1:0]    out_sum_r, out_sum_nxt;
  logic [CFG_BITS-1:0]    wl_r, wl_nxt;
  logic [CFG_BITS-1:0]    kc_r, kc_nxt;

  logic [FILL_BITS-1:0]   len_eff;
  logic [FILL_BITS-1:0]   keep_eff;
  logic [FILL_BITS-1:0]   fill_m1;
  logic [FILL_BITS-1:0]   fill_p1;
  cell_ctrl_t             ctrl;
  logic                   grp_en;
  grp_sel_t               grp [NUM_GRP];

  logic [IDX_BITS-1:0]    del_idx;
  logic [SAMPLE_BITS-1:0] del_val;
  logic [SAMPLE_BITS-1:0] k_val;
  logic [SAMPLE_BITS-1:0] km1_val;
  logic                   d_lt_keep;
  logic                   pk;
  logic                   emit;
  logic                   commit;
  logic                   accept;
  logic                   cfg_wr;

  swks_chain u_chain (
    .clk    (clk),
    .ctrl   (ctrl),
    .keep   (keep_eff),
    .grp_en (grp_en),
    .grp    (grp)
  );

  always_comb begin
    if (wl_r == '0) begin
      len_eff = FILL_BITS'(1);
    end else if (32'(wl_r) > 32'(WINDOW_MAX)) begin
      len_eff = FILL_BITS'(WINDOW_MAX);
    end else begin
      len_eff = FILL_BITS'(wl_r);
    end
    if (32'(kc_r) > 32'(len_eff)) begin
      keep_eff = len_eff;
    end else begin
      keep_eff = FILL_BITS'(kc_r);
    end
  end

  // second select level across the groups
  always_comb begin
    del_idx = '0;
    del_val = '0;
    k_val   = '0;
    km1_val = '0;
    for (int g = 0; g < NUM_GRP; g++) begin
      if (grp[g].del_any) begin
        del_idx = del_idx | IDX_BITS'(g * GRP_SIZE) | IDX_BITS'(grp[g].del_loc);
      end
      del_val = del_val | grp[g].del_val;
      k_val   = k_val | grp[g].k_val;
      km1_val = km1_val | grp[g].km1_val;
    end
  end

  assign cfg_wr = psel && penable && pwrite && pready;
  assign accept = in_valid && in_ready;

  always_comb begin
    fill_m1 = fill_r - FILL_BITS'(1);
    fill_p1 = fill_r + FILL_BITS'(1);

    ctrl.op      = OP_HOLD;
    ctrl.sample  = sample_r;
    ctrl.del_idx = del_idx;
    ctrl.fill    = fill_r;
    ctrl.age_top = fill_m1[IDX_BITS-1:0];

    state_nxt     = state_r;
    sample_nxt    = sample_r;
    fill_nxt      = fill_r;
    sum_nxt       = sum_r;
    vkm1_nxt      = vkm1_r;
    out_sum_nxt   = out_sum_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    wl_nxt        = wl_r;
    kc_nxt        = kc_r;
    grp_en        = 1'b0;
    in_ready      = 1'b0;

    d_lt_keep = FILL_BITS'(del_idx) < keep_eff;
    pk        = (fill_r < keep_eff) || (sample_r < vkm1_r);
    emit      = fill_p1 == len_eff;
    commit    = !emit || !out_valid_r || out_ready;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          sample_nxt = in_sample;
          state_nxt  = ST_SEL;
        end
      end
      ST_SEL: begin
        grp_en    = 1'b1;
        state_nxt = ST_DEL;
      end
      ST_DEL: begin
        vkm1_nxt = km1_val;
        if (fill_r == len_eff) begin
          // retire the oldest cell; the keep boundary moves if it sat below it
          ctrl.op  = OP_DEL;
          fill_nxt = fill_m1;
          if (d_lt_keep) begin
            vkm1_nxt = k_val;
            if (keep_eff < fill_r) begin
              sum_nxt = sum_r - SUM_BITS'(del_val) + SUM_BITS'(k_val);
            end else begin
              sum_nxt = sum_r - SUM_BITS'(del_val);
            end
          end
        end
        state_nxt = ST_INS;
      end
      ST_INS: begin
        if (commit) begin
          ctrl.op  = OP_INS;
          fill_nxt = fill_p1;
          if (pk) begin
            if (fill_r >= keep_eff) begin
              sum_nxt = sum_r + SUM_BITS'(sample_r) - SUM_BITS'(vkm1_r);
            end else begin
              sum_nxt = sum_r + SUM_BITS'(sample_r);
            end
          end
          if (emit) begin
            out_valid_nxt = 1'b1;
            out_sum_nxt   = sum_nxt;
          end
          in_ready = 1'b1;
          if (in_valid) begin
            sample_nxt = in_sample;
            state_nxt  = ST_SEL;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_wr) begin
      unique case (paddr[2])
        REG_WINDOW_LENGTH: wl_nxt = pwdata[CFG_BITS-1:0];
        REG_KEEP_COUNT:    kc_nxt = pwdata[CFG_BITS-1:0];
        default: begin
        end
      endcase
      fill_nxt = '0;
      sum_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
      wl_r        <= CFG_BITS'(1);
      kc_r        <= CFG_BITS'(1);
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
      wl_r        <= wl_nxt;
      kc_r        <= kc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sample_r  <= sample_nxt;
    vkm1_r    <= vkm1_nxt;
    out_sum_r <= out_sum_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_smallest_sum = out_sum_r;
  assign pready           = 1'b1;
  assign prdata           = paddr[2] ? 32'(kc_r) : 32'(wl_r);

  a_fill_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= len_eff)
    else $error("fill count exceeds window length");

  a_ready_states: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (state_r == ST_IDLE || state_r == ST_INS))
    else $error("input ready outside idle or insert");

  a_accept_to_select: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_SEL)
    else $error("transfer not followed by select cycle");

  a_result_from_insert: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_INS)
    else $error("result raised outside insert cycle");

endmodule
